// ===== src/matrix_multiply_macros.svh =====
// Assertion macros used by the matrix multiply checker.
`ifndef MATRIX_MULTIPLY_MACROS_SVH
`define MATRIX_MULTIPLY_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/mm_pkg.sv =====
// Shared types and constants of the matrix multiply block.
package mm_pkg;

    localparam int DATA_W    = 32;
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int ACC_W     = PROD_W + 4;
    localparam int FRAC_W    = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROWS_A    = 2'd0,
        REG_INNER_LEN = 2'd1,
        REG_COLS_B    = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } feed_ctl_t;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              sat;
    } res_t;

endpackage

// ===== src/mm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module mm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/mm_cell.sv =====
// One multiply-accumulate cell of the chain, holding one column of the right matrix.
module mm_cell import mm_pkg::*; #(
    parameter int MAX_DIM = 8,
    localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  feed_ctl_t         ctl_in,
    input  logic [IDX_W-1:0]  k_in,
    input  logic [DATA_W-1:0] a_in,
    output feed_ctl_t         ctl_out,
    output logic [IDX_W-1:0]  k_out,
    output logic [DATA_W-1:0] a_out,
    input  logic              b_wr_en,
    input  logic [IDX_W-1:0]  b_wr_row,
    input  logic [DATA_W-1:0] b_wr_data,
    input  logic              res_shift,
    input  res_t              res_in,
    output res_t              res_out,
    output logic              done
);

    localparam int SUM_W = ACC_W - FRAC_W;

    logic [DATA_W-1:0]        bank_reg [MAX_DIM];
    feed_ctl_t                ctl_reg;
    logic [IDX_W-1:0]         k_reg;
    logic [DATA_W-1:0]        a_reg;
    feed_ctl_t                pctl_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic                     done_reg;
    res_t                     res_reg;
    res_t                     res_next;
    logic signed [DATA_W-1:0] a_s;
    logic signed [DATA_W-1:0] b_s;
    logic [SUM_W-1:0]         sum_q;
    logic [SUM_W-DATA_W:0]    sum_top;
    logic                     ovf;

    assign a_s       = a_in;
    assign b_s       = bank_reg[k_in];
    assign prod_next = PROD_W'(a_s) * PROD_W'(b_s);
    assign acc_next  = pctl_reg.first ? ACC_W'(prod_reg) : acc_reg + ACC_W'(prod_reg);

    assign sum_q   = acc_reg[ACC_W-1:FRAC_W];
    assign sum_top = sum_q[SUM_W-1:DATA_W-1];
    assign ovf     = !((&sum_top) || (~|sum_top));

    always_comb
    begin
        res_next = res_reg;
        if (res_shift)
        begin
            res_next = res_in;
        end
        else if (done_reg)
        begin
            res_next.sat = ovf;
            if (!ovf)
            begin
                res_next.value = sum_q[DATA_W-1:0];
            end
            else if (sum_q[SUM_W-1])
            begin
                res_next.value = {1'b1, {(DATA_W-1){1'b0}}};
            end
            else
            begin
                res_next.value = {1'b0, {(DATA_W-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg  <= '0;
            pctl_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            ctl_reg  <= ctl_in;
            pctl_reg <= ctl_in;
            done_reg <= pctl_reg.valid && pctl_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_wr_en)
        begin
            bank_reg[b_wr_row] <= b_wr_data;
        end
        k_reg   <= k_in;
        a_reg   <= a_in;
        res_reg <= res_next;
        if (ctl_in.valid)
        begin
            prod_reg <= prod_next;
        end
        if (pctl_reg.valid)
        begin
            acc_reg <= acc_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign k_out   = k_reg;
    assign a_out   = a_reg;
    assign res_out = res_reg;
    assign done    = done_reg;

endmodule

// ===== src/matrix_multiply.sv =====
// Top level of the streaming matrix multiply built on a chain of MAC cells.
// Loading takes one word per cycle while s_tready is high: rows_a*inner_len words of A,
// then inner_len*cols_b of B. After the last B word each row of C passes the wait
// state, the feed state and the flush state while the MAC cell chain drains; then its
// cols_b words leave one per cycle while m_tready is high, before the next row is fed.
// Reset (rst_n, asynchronous, active low) clears control state and sets all sizes to 8.
module matrix_multiply import mm_pkg::*; #(
    parameter int MAX_DIM = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [DATA_W-1:0]    s_tdata,   // [31:0] elem_value
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [DATA_W-1:0]    m_tdata,   // [31:0] prod_value
    output logic                 m_tlast,
    output logic                 m_tuser,   // [0] saturated
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CNT_W = $clog2(MAX_DIM + 1);
    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LC_W  = $clog2(2 * DEPTH);
    localparam int TOT_W = LC_W + 1;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_WAIT,
        ST_FEED,
        ST_FLUSH
    } state_t;

    function automatic logic [CNT_W-1:0] eff_dim(input logic [CFG_W-1:0] d);
        if (d == '0)
        begin
            return CNT_W'(1);
        end
        else if (d > CFG_W'(MAX_DIM))
        begin
            return CNT_W'(MAX_DIM);
        end
        else
        begin
            return CNT_W'(d);
        end
    endfunction

    state_t            state_reg, state_next;
    logic [CFG_W-1:0]  rows_a_reg, rows_a_next;
    logic [CFG_W-1:0]  inner_len_reg, inner_len_next;
    logic [CFG_W-1:0]  cols_b_reg, cols_b_next;
    logic [LC_W-1:0]   load_count_reg, load_count_next;
    logic [IDX_W-1:0]  b_k_reg, b_k_next;
    logic [IDX_W-1:0]  b_c_reg, b_c_next;
    logic [IDX_W-1:0]  feed_k_reg, feed_k_next;
    logic [IDX_W-1:0]  row_reg, row_next;
    logic [AW-1:0]     a_ptr_reg, a_ptr_next;
    feed_ctl_t         feed_ctl_reg, feed_ctl_next;
    logic [IDX_W-1:0]  feed_kd_reg, feed_kd_next;
    logic [CNT_W-1:0]  out_left_reg, out_left_next;
    logic              out_last_reg, out_last_next;

    logic [CNT_W-1:0]  nr, nk, nc;
    logic [TOT_W-1:0]  na, total;
    logic              in_acc, out_acc, cfg_acc;
    logic              in_a_phase, load_done;
    logic              a_wr_en, b_wr_en, rd_en;
    logic [DATA_W-1:0] a_rd_data;

    feed_ctl_t         ctl_w  [MAX_DIM+1];
    logic [IDX_W-1:0]  k_w    [MAX_DIM+1];
    logic [DATA_W-1:0] a_w    [MAX_DIM+1];
    res_t              res_w  [MAX_DIM+1];
    logic              done_w [MAX_DIM];
    logic              b_en_w [MAX_DIM];

    assign nr    = eff_dim(rows_a_reg);
    assign nk    = eff_dim(inner_len_reg);
    assign nc    = eff_dim(cols_b_reg);
    assign na    = TOT_W'(nr) * TOT_W'(nk);
    assign total = na + TOT_W'(nk) * TOT_W'(nc);

    assign s_tready  = (state_reg == ST_LOAD);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = (out_left_reg != '0);
    assign in_acc    = s_tvalid && s_tready;
    assign out_acc   = m_tvalid && m_tready;
    assign cfg_acc   = cfg_valid && cfg_ready;

    assign in_a_phase = (TOT_W'(load_count_reg) < na);
    assign load_done  = ((TOT_W'(load_count_reg) + TOT_W'(1)) == total);
    assign a_wr_en    = in_acc && in_a_phase;
    assign b_wr_en    = in_acc && !in_a_phase;
    assign rd_en      = (state_reg == ST_FEED);

    always_comb
    begin
        state_next      = state_reg;
        rows_a_next     = rows_a_reg;
        inner_len_next  = inner_len_reg;
        cols_b_next     = cols_b_reg;
        load_count_next = load_count_reg;
        b_k_next        = b_k_reg;
        b_c_next        = b_c_reg;
        feed_k_next     = feed_k_reg;
        row_next        = row_reg;
        a_ptr_next      = a_ptr_reg;
        feed_ctl_next   = '0;
        feed_kd_next    = feed_kd_reg;
        out_left_next   = out_left_reg;
        out_last_next   = out_last_reg;

        if (out_acc)
        begin
            out_left_next = out_left_reg - CNT_W'(1);
        end

        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_acc)
                begin
                    if (!in_a_phase)
                    begin
                        if ((CNT_W'(b_c_reg) + CNT_W'(1)) == nc)
                        begin
                            b_c_next = '0;
                            b_k_next = IDX_W'(b_k_reg + 1'b1);
                        end
                        else
                        begin
                            b_c_next = IDX_W'(b_c_reg + 1'b1);
                        end
                    end
                    if (load_done)
                    begin
                        load_count_next = '0;
                        b_k_next        = '0;
                        b_c_next        = '0;
                        row_next        = '0;
                        feed_k_next     = '0;
                        a_ptr_next      = '0;
                        state_next      = ST_WAIT;
                    end
                    else
                    begin
                        load_count_next = LC_W'(load_count_reg + 1'b1);
                    end
                end
            end
            ST_WAIT:
            begin
                if (out_left_reg == '0)
                begin
                    state_next = ST_FEED;
                end
            end
            ST_FEED:
            begin
                feed_ctl_next.valid = 1'b1;
                feed_ctl_next.first = (feed_k_reg == '0);
                feed_ctl_next.last  = ((CNT_W'(feed_k_reg) + CNT_W'(1)) == nk);
                feed_kd_next        = feed_k_reg;
                a_ptr_next          = AW'(a_ptr_reg + 1'b1);
                if (feed_ctl_next.last)
                begin
                    feed_k_next = '0;
                    state_next  = ST_FLUSH;
                end
                else
                begin
                    feed_k_next = IDX_W'(feed_k_reg + 1'b1);
                end
            end
            ST_FLUSH:
            begin
                if (done_w[MAX_DIM-1])
                begin
                    out_left_next = nc;
                    out_last_next = ((CNT_W'(row_reg) + CNT_W'(1)) == nr);
                    if (out_last_next)
                    begin
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        row_next   = IDX_W'(row_reg + 1'b1);
                        state_next = ST_WAIT;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase

        if (cfg_acc)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ROWS_A:
                begin
                    rows_a_next     = cfg_data;
                    load_count_next = '0;
                    b_k_next        = '0;
                    b_c_next        = '0;
                end
                REG_INNER_LEN:
                begin
                    inner_len_next  = cfg_data;
                    load_count_next = '0;
                    b_k_next        = '0;
                    b_c_next        = '0;
                end
                REG_COLS_B:
                begin
                    cols_b_next     = cfg_data;
                    load_count_next = '0;
                    b_k_next        = '0;
                    b_c_next        = '0;
                end
                default:
                begin
                    rows_a_next = rows_a_next;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            rows_a_reg     <= CFG_W'(8);
            inner_len_reg  <= CFG_W'(8);
            cols_b_reg     <= CFG_W'(8);
            load_count_reg <= '0;
            b_k_reg        <= '0;
            b_c_reg        <= '0;
            feed_k_reg     <= '0;
            row_reg        <= '0;
            a_ptr_reg      <= '0;
            feed_ctl_reg   <= '0;
            feed_kd_reg    <= '0;
            out_left_reg   <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rows_a_reg     <= rows_a_next;
            inner_len_reg  <= inner_len_next;
            cols_b_reg     <= cols_b_next;
            load_count_reg <= load_count_next;
            b_k_reg        <= b_k_next;
            b_c_reg        <= b_c_next;
            feed_k_reg     <= feed_k_next;
            row_reg        <= row_next;
            a_ptr_reg      <= a_ptr_next;
            feed_ctl_reg   <= feed_ctl_next;
            feed_kd_reg    <= feed_kd_next;
            out_left_reg   <= out_left_next;
            out_last_reg   <= out_last_next;
        end
    end

    mm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_left_store (
        .clk     (clk),
        .wr_en   (a_wr_en),
        .wr_addr (load_count_reg[AW-1:0]),
        .wr_data (s_tdata),
        .rd_en   (rd_en),
        .rd_addr (a_ptr_reg),
        .rd_data (a_rd_data)
    );

    assign ctl_w[0]       = feed_ctl_reg;
    assign k_w[0]         = feed_kd_reg;
    assign a_w[0]         = a_rd_data;
    assign res_w[MAX_DIM] = '0;

    for (genvar c = 0; c < MAX_DIM; c++)
    begin : g_cell
        assign b_en_w[c] = b_wr_en && (b_c_reg == IDX_W'(c));

        mm_cell #(
            .MAX_DIM (MAX_DIM)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl_in    (ctl_w[c]),
            .k_in      (k_w[c]),
            .a_in      (a_w[c]),
            .ctl_out   (ctl_w[c+1]),
            .k_out     (k_w[c+1]),
            .a_out     (a_w[c+1]),
            .b_wr_en   (b_en_w[c]),
            .b_wr_row  (b_k_reg),
            .b_wr_data (s_tdata),
            .res_shift (out_acc),
            .res_in    (res_w[c+1]),
            .res_out   (res_w[c]),
            .done      (done_w[c])
        );
    end

    assign m_tdata = res_w[0].value;
    assign m_tuser = res_w[0].sat;
    assign m_tlast = out_last_reg && (out_left_reg == CNT_W'(1));

endmodule

// ===== src/mm_checker.sv =====
// Port-level assertion checker for the matrix multiply block and its bind.
`include "matrix_multiply_macros.svh"

module mm_checker import mm_pkg::*; (
    input logic              clk,
    input logic              rst_n,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [DATA_W-1:0] m_tdata,
    input logic              m_tlast,
    input logic              m_tuser
);

    // A stalled output word must not change.
    `MM_ASSERT_NEXT(a_out_hold,
        m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser),
        "output word changed while stalled")

    // A saturated word carries one of the two clip values.
    `MM_ASSERT_NOW(a_sat_clip,
        m_tvalid && m_tuser,
        m_tdata == 32'h7fffffff || m_tdata == 32'h80000000,
        "saturated flag without clip value")

    // The final word of a product is never followed directly by another word.
    `MM_ASSERT_NEXT(a_gap_after_last,
        m_tvalid && m_tready && m_tlast,
        !m_tvalid,
        "word right after the final word")

    // Taking an input word never starts a new output burst in the next cycle.
    `MM_ASSERT_NEXT(a_no_burst_on_load,
        s_tvalid && s_tready,
        !$rose(m_tvalid),
        "output burst started right after an input word")

endmodule

bind matrix_multiply mm_checker u_mm_checker (.*);
